// File: sv/sine_pwm_reference_nco_macros.svh
// ============================================================================
// Sine PWM reference NCO assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ============================================================================
`ifndef SINE_PWM_REFERENCE_NCO_MACROS_SVH
`define SINE_PWM_REFERENCE_NCO_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SPN_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SPN_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/spn_pkg.sv
// ============================================================================
// Sine PWM reference NCO package
// Field widths, register codes, reset values and the sine table generator.
// ============================================================================
`default_nettype none

package spn_pkg;

  // Parameter defaults.
  localparam int unsigned TABLE_DEPTH_DEF     = 256;
  localparam int unsigned PHASE_FRAC_BITS_DEF = 24;
  localparam int unsigned SAMPLE_BITS_DEF     = 12;
  localparam int unsigned ROM_WIDTH_DEF       = 16;

  // Fixed field and register widths.
  localparam int unsigned SAMPLE_FIELD_W = 12;
  localparam int unsigned CMP_W          = 16;
  localparam int unsigned IDX_FIELD_W    = 8;
  localparam int unsigned STEP_W         = 32;
  localparam int unsigned SLOPE_W        = 20;
  localparam int unsigned DUTY_W         = 16;
  localparam int unsigned PERIOD_W       = 16;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned DIGIT_BITS     = 4;
  localparam int unsigned ROM_MAX_W      = 24;

  // Register reset values.
  localparam logic [STEP_W-1:0]   STEP_BASE_RST      = 32'd2147484;
  localparam logic [SLOPE_W-1:0]  STEP_PER_COUNT_RST = 20'd9964;
  localparam logic [STEP_W-1:0]   STEP_LIMIT_RST     = 32'd42949673;
  localparam logic [PERIOD_W-1:0] CARRIER_PERIOD_RST = 16'd3750;
  localparam logic [DUTY_W-1:0]   DUTY_FLOOR_RST     = 16'd1311;
  localparam logic [DUTY_W-1:0]   DUTY_CEILING_RST   = 16'd64225;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_BASE      = 3'd0,
    REG_STEP_PER_COUNT = 3'd1,
    REG_STEP_LIMIT     = 3'd2,
    REG_CARRIER_PERIOD = 3'd3,
    REG_DUTY_FLOOR     = 3'd4,
    REG_DUTY_CEILING   = 3'd5
  } spn_reg_e;

  // Status of the shared digit-serial multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } spn_mul_stat_t;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

  // One table entry: 0.5 + 0.5*sin of the 32-bit turn fraction ph, rounded to
  // rom_w bits. Evaluated at elaboration only, to build a constant table.
  function automatic logic [ROM_MAX_W-1:0] sine_rom_entry(input logic [63:0] ph,
                                                         input int unsigned rom_w);
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] d;
    logic [63:0] v;
    logic [63:0] half;
    logic [63:0] top;
    quad = ph[31:30];
    r    = ph & (Q30_ONE - 64'd1);
    u    = quad[0] ? (Q30_ONE - r) : r;
    x    = (u * Q30_HALF_PI) >> 30;
    x2   = (x * x) >> 30;
    // Horner form of the odd series up to the x^13 term.
    t    = Q30_ONE;
    t    = Q30_ONE - ((x2 * t) >> 30) / 156;
    t    = Q30_ONE - ((x2 * t) >> 30) / 110;
    t    = Q30_ONE - ((x2 * t) >> 30) / 72;
    t    = Q30_ONE - ((x2 * t) >> 30) / 42;
    t    = Q30_ONE - ((x2 * t) >> 30) / 20;
    t    = Q30_ONE - ((x2 * t) >> 30) / 6;
    s    = (x * t) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    half = 64'd1 << (rom_w - 1);
    top  = (64'd1 << rom_w) - 64'd1;
    d    = ((s << (rom_w - 1)) + (64'd1 << 29)) >> 30;
    if (quad[1]) begin
      v = (d >= half) ? 64'd0 : (half - d);
    end else begin
      v = half + d;
    end
    if (v > top) begin
      v = top;
    end
    return v[ROM_MAX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/spn_if.sv
// ============================================================================
// Sine PWM reference NCO channels
// Valid/ready channels for control samples and PWM compare results.
// ============================================================================
`default_nettype none

interface spn_sample_if import spn_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [SAMPLE_FIELD_W-1:0] control_sample;

  modport source (output valid, output control_sample, input ready);
  modport sink   (input valid, input control_sample, output ready);
endinterface

interface spn_result_if import spn_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CMP_W-1:0]       compare_value;
  logic [IDX_FIELD_W-1:0] table_index;

  modport source (output valid, output compare_value, output table_index, input ready);
  modport sink   (input valid, input compare_value, input table_index, output ready);
endinterface

`default_nettype wire

// File: sv/spn_digit_mul.sv
// ============================================================================
// Digit-serial multiply-accumulate
// Computes init + a * b, taking one DIG_W-bit digit of b per clock cycle.
// ============================================================================
`default_nettype none

module spn_digit_mul import spn_pkg::*; #(
  parameter int unsigned A_W   = SLOPE_W,
  parameter int unsigned B_W   = DUTY_W,
  parameter int unsigned P_W   = STEP_W + 1,
  parameter int unsigned DIG_W = DIGIT_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [A_W-1:0] a_i,
  input  logic [B_W-1:0] b_i,
  input  logic [P_W-1:0] init_i,
  output spn_mul_stat_t stat_o,
  output logic [P_W-1:0] prod_o
);

  localparam int unsigned NDIG   = (B_W + DIG_W - 1) / DIG_W;
  localparam int unsigned CNT_W  = $clog2(NDIG + 1);
  localparam int unsigned BPAD_W = NDIG * DIG_W;

  logic [P_W-1:0]       acc_q, acc_d;
  logic [P_W-1:0]       mcand_q, mcand_d;
  logic [BPAD_W-1:0]    mplier_q, mplier_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [P_W+DIG_W-1:0] partial;

  assign partial = (P_W + DIG_W)'(mplier_q[DIG_W-1:0]) * (P_W + DIG_W)'(mcand_q);

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      acc_d    = init_i;
      mcand_d  = P_W'(a_i);
      mplier_d = BPAD_W'(b_i);
      cnt_d    = CNT_W'(NDIG);
      busy_d   = 1'b1;
    end else if (busy_q) begin
      acc_d    = acc_q + partial[P_W-1:0];
      mcand_d  = mcand_q << DIG_W;
      mplier_d = mplier_q >> DIG_W;
      cnt_d    = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

`default_nettype wire

// File: sv/sine_pwm_reference_nco.sv
// ============================================================================
// Sine PWM reference NCO
// Maps a control sample to a phase step, advances a wrapping phase
// accumulator, looks up a sine duty and scales it to a PWM compare count.
// ============================================================================
//
//   port       dir  width  contents
//   ---------  ---  -----  --------------------------------------------
//   sample_i   in   12     control_sample
//   result_o   out  16+8   compare_value, table_index
//   cfg_*      in   3+32   register index and write data, write only
//
// A new control sample is accepted only in the idle state, once the previous
// result has been registered. The 4-bit digit-serial multiplier is used once
// for the phase step and once for the compare value. The sine table is
// constant, so reset needs no clearing.
// A finished result waits in the output register while the next sample is
// taken; the block stalls only when a second result is ready before the
// first has been taken.
`include "sine_pwm_reference_nco_macros.svh"
`default_nettype none

module sine_pwm_reference_nco import spn_pkg::*; #(
  parameter int unsigned TABLE_DEPTH     = TABLE_DEPTH_DEF,
  parameter int unsigned PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF,
  parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int unsigned ROM_WIDTH       = ROM_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  spn_sample_if.sink            sample_i,
  spn_result_if.source          result_o
);

  localparam int unsigned IDX_W     = $clog2(TABLE_DEPTH);
  localparam int unsigned PH_W      = IDX_W + PHASE_FRAC_BITS;
  localparam int unsigned SUM_W     = ((PH_W > STEP_W) ? PH_W : STEP_W) + 1;
  localparam int unsigned WRAP_N    = SUM_W - PH_W + 1;
  localparam int unsigned DIV_W     = SUM_W + 1;
  localparam int unsigned MUL_B_W   = (SAMPLE_BITS > DUTY_W) ? SAMPLE_BITS : DUTY_W;
  localparam int unsigned MUL_P_W   =
    (((SAMPLE_BITS + SLOPE_W) > STEP_W) ? (SAMPLE_BITS + SLOPE_W) : STEP_W) + 1;
  localparam logic [DIV_W-1:0] PERIOD   = DIV_W'(TABLE_DEPTH) << PHASE_FRAC_BITS;
  localparam logic [DIV_W-1:0] DIV_INIT = PERIOD << (WRAP_N - 1);
  localparam logic [SAMPLE_FIELD_W-1:0] SAMPLE_MASK =
    SAMPLE_FIELD_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_WRAP,
    S_LOOKUP,
    S_DUTY,
    S_HOLD
  } state_e;

  // Configuration registers.
  logic [STEP_W-1:0]   step_base_q;
  logic [SLOPE_W-1:0]  step_per_count_q;
  logic [STEP_W-1:0]   step_limit_q;
  logic [PERIOD_W-1:0] carrier_period_q;
  logic [DUTY_W-1:0]   duty_floor_q;
  logic [DUTY_W-1:0]   duty_ceiling_q;

  state_e                 state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  logic [CMP_W-1:0]       cmp_q, cmp_d;
  logic [IDX_FIELD_W-1:0] tidx_q, tidx_d;
  logic [PH_W-1:0]        phase_q, phase_d;
  logic [SUM_W-1:0]       rem_q, rem_d;
  logic [DIV_W-1:0]       div_q, div_d;

  logic                   in_fire;
  logic                   out_fire;
  logic                   out_free;
  logic                   mul_start;
  logic [SLOPE_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [MUL_P_W-1:0]     mul_init;
  logic [MUL_P_W-1:0]     mul_prod;
  spn_mul_stat_t          mul_stat;

  logic [STEP_W-1:0]           step_clamped;
  logic [SUM_W-1:0]            wrap_sum;
  logic                        rem_ge;
  logic [SUM_W-1:0]            rem_sub;
  logic [IDX_W-1:0]            phase_idx;
  logic [ROM_WIDTH-1:0]        rom_tbl [TABLE_DEPTH];
  logic [ROM_WIDTH-1:0]        rom_val;
  logic [ROM_WIDTH+DUTY_W-1:0] rom_ext;
  logic [DUTY_W-1:0]           duty_raw;
  logic [DUTY_W-1:0]           duty_lo;
  logic [DUTY_W-1:0]           duty_clamped;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_base_q      <= STEP_BASE_RST;
      step_per_count_q <= STEP_PER_COUNT_RST;
      step_limit_q     <= STEP_LIMIT_RST;
      carrier_period_q <= CARRIER_PERIOD_RST;
      duty_floor_q     <= DUTY_FLOOR_RST;
      duty_ceiling_q   <= DUTY_CEILING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEP_BASE:      step_base_q      <= cfg_wdata_i[STEP_W-1:0];
        REG_STEP_PER_COUNT: step_per_count_q <= cfg_wdata_i[SLOPE_W-1:0];
        REG_STEP_LIMIT:     step_limit_q     <= cfg_wdata_i[STEP_W-1:0];
        REG_CARRIER_PERIOD: carrier_period_q <= cfg_wdata_i[PERIOD_W-1:0];
        REG_DUTY_FLOOR:     duty_floor_q     <= cfg_wdata_i[DUTY_W-1:0];
        REG_DUTY_CEILING:   duty_ceiling_q   <= cfg_wdata_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Constant sine table
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] Ph = (64'(g) << 32) / TABLE_DEPTH;
    assign rom_tbl[g] = ROM_WIDTH'(sine_rom_entry(Ph, ROM_WIDTH));
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  assign in_fire  = sample_i.valid && sample_i.ready;
  assign out_fire = out_valid_q && result_o.ready;
  assign out_free = !out_valid_q || result_o.ready;

  assign step_clamped = (mul_prod > MUL_P_W'(step_limit_q)) ? step_limit_q
                                                            : mul_prod[STEP_W-1:0];
  assign wrap_sum     = SUM_W'(phase_q) + SUM_W'(step_clamped);

  // One restoring step of the modulo: subtract the period scaled by the
  // current power of two when it fits.
  assign rem_ge  = DIV_W'(rem_q) >= div_q;
  assign rem_sub = rem_ge ? (rem_q - div_q[SUM_W-1:0]) : rem_q;

  assign phase_idx = phase_q[PH_W-1:PHASE_FRAC_BITS];
  assign rom_val   = rom_tbl[phase_idx];
  // Align the table word to Q0.16 by keeping its top sixteen bits.
  assign rom_ext   = {rom_val, DUTY_W'(0)};
  assign duty_raw  = rom_ext[ROM_WIDTH+DUTY_W-1 -: DUTY_W];
  // The floor is applied first, so the ceiling wins when the two cross.
  assign duty_lo      = (duty_raw < duty_floor_q) ? duty_floor_q : duty_raw;
  assign duty_clamped = (duty_lo > duty_ceiling_q) ? duty_ceiling_q : duty_lo;

  // The multiplier forms base + sample * slope on acceptance, and
  // duty * carrier period in the lookup state.
  assign mul_start = in_fire || (state_q == S_LOOKUP);
  assign mul_a     = (state_q == S_IDLE) ? step_per_count_q : SLOPE_W'(carrier_period_q);
  assign mul_b     = (state_q == S_IDLE) ? MUL_B_W'(sample_i.control_sample & SAMPLE_MASK)
                                         : MUL_B_W'(duty_clamped);
  assign mul_init  = (state_q == S_IDLE) ? MUL_P_W'(step_base_q) : '0;

  spn_digit_mul #(
    .A_W   (SLOPE_W),
    .B_W   (MUL_B_W),
    .P_W   (MUL_P_W),
    .DIG_W (DIGIT_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .init_i  (mul_init),
    .stat_o  (mul_stat),
    .prod_o  (mul_prod)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;
    cmp_d       = cmp_q;
    tidx_d      = tidx_q;
    phase_d     = phase_q;
    rem_d       = rem_q;
    div_d       = div_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (mul_stat.done) begin
          rem_d   = wrap_sum;
          div_d   = DIV_INIT;
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        rem_d = rem_sub;
        div_d = div_q >> 1;
        if (div_q == PERIOD) begin
          phase_d = rem_sub[PH_W-1:0];
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_d = S_DUTY;
      end
      S_DUTY: begin
        if (mul_stat.done) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            cmp_d       = mul_prod[2*CMP_W-1:CMP_W];
            tidx_d      = IDX_FIELD_W'(phase_idx);
            state_d     = S_IDLE;
          end else begin
            state_d = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          cmp_d       = mul_prod[2*CMP_W-1:CMP_W];
          tidx_d      = IDX_FIELD_W'(phase_idx);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cmp_q       <= '0;
      tidx_q      <= '0;
      phase_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cmp_q       <= cmp_d;
      tidx_q      <= tidx_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign sample_i.ready         = (state_q == S_IDLE);
  assign result_o.valid         = out_valid_q;
  assign result_o.compare_value = cmp_q;
  assign result_o.table_index   = tidx_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SPN_ASSERT(a_phase_in_range, clk_i, rst_ni, DIV_W'(phase_q) < PERIOD, "phase exceeds table length")
  `SPN_ASSERT(a_mul_no_restart, clk_i, rst_ni, mul_start |-> !mul_stat.busy, "multiplier restarted while busy")
  `SPN_ASSERT_NEXT(a_accept_starts_mul, clk_i, rst_ni, in_fire, mul_stat.busy, "accepted sample did not start the multiplier")
  `SPN_ASSERT(a_done_expected, clk_i, rst_ni, mul_stat.done |-> (state_q == S_STEP || state_q == S_DUTY), "multiplier finished outside a multiply state")

endmodule

`default_nettype wire

// File: test/tb_sine_pwm_reference_nco.sv
// ============================================================================
// Sine PWM reference NCO testbench
// Sends control samples through the valid/ready channel under changing register
// settings and checks each compare value and table index against a cycle-free
// prediction of the phase accumulator, the sine table and the duty clamp.
// ============================================================================
`default_nettype none

module tb_sine_pwm_reference_nco import spn_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_LEN     = 256;
  localparam int unsigned FRAC_BITS     = 24;
  // The accumulator wraps at TABLE_LEN << FRAC_BITS, which is exactly 2**32.
  localparam int unsigned PHASE_W       = 32;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned TAIL_CYCLES   = 48;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned IDLE_PCT      = 38;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 200;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [63:0] Q30_UNIT         = 64'd1073741824;
  localparam logic [63:0] Q30_QUARTER_TURN = 64'd1686629713;
  localparam logic [63:0] HORNER_DIV [6]   = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  typedef struct packed {
    logic [CMP_W-1:0]       compare_value;
    logic [IDX_FIELD_W-1:0] table_index;
  } pwm_result_t;

  typedef enum logic {ROW_REG_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_data;
    logic [SAMPLE_FIELD_W-1:0] sample;
    logic                    fix_cmp;
    logic [CMP_W-1:0]        cmp;
    logic                    fix_idx;
    logic [IDX_FIELD_W-1:0]  idx;
  } plan_row_t;

  // Directed plan. Typed expectations appear only where they are obvious;
  // other sample rows rely on the predictor.
  localparam int unsigned PLAN_LEN = 39;
  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    // Reset settings, phase starts at zero.
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd0,    1'b1, 16'd1875,  1'b1, 8'd0},
    // Step that lands exactly on the quarter turn, where the sine saturates.
    '{ROW_REG_WRITE, REG_STEP_BASE,      32'd1071594340, 12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_STEP_PER_COUNT, 32'd0,          12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_STEP_LIMIT,     32'hFFFF_FFFF,  12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_CARRIER_PERIOD, 32'd65535,      12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_DUTY_FLOOR,     32'd0,          12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_DUTY_CEILING,   32'd65535,      12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd4095, 1'b1, 16'd65534, 1'b1, 8'd64},
    // Quarter-turn steps around the whole table.
    '{ROW_REG_WRITE, REG_STEP_BASE,      32'h4000_0000,  12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd0,    1'b1, 16'd32767, 1'b1, 8'd128},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd2048, 1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd1,    1'b1, 16'd32767, 1'b1, 8'd0},
    // Limit below the base: the limit wins.
    '{ROW_REG_WRITE, REG_STEP_BASE,      32'hFFFF_FFFF,  12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_STEP_PER_COUNT, 32'h000F_FFFF,  12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_STEP_LIMIT,     32'h0100_0000,  12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd4095, 1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    // Near full-turn steps that wrap the accumulator.
    '{ROW_REG_WRITE, REG_STEP_LIMIT,     32'hFFFF_FFFF,  12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd4095, 1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd2047, 1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_STEP_BASE,      32'd0,          12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd4095, 1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'hAAA,  1'b0, 16'd0,     1'b0, 8'd0},
    // Writes to unmapped indexes must leave every register alone.
    '{ROW_REG_WRITE, REG_SPARE_6,        32'hFFFF_FFFF,  12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_SPARE_7,        32'd0,          12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'h555,  1'b0, 16'd0,     1'b0, 8'd0},
    // Floor above ceiling: the ceiling is applied last.
    '{ROW_REG_WRITE, REG_DUTY_FLOOR,     32'd60000,      12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_DUTY_CEILING,   32'd1000,       12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd4095, 1'b1, 16'd999,   1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd0,    1'b1, 16'd999,   1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_CARRIER_PERIOD, 32'd0,          12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd1234, 1'b1, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_CARRIER_PERIOD, 32'd1,          12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_DUTY_FLOOR,     32'd0,          12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_DUTY_CEILING,   32'd65535,      12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd2222, 1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_CARRIER_PERIOD, 32'd65535,      12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_REG_WRITE, REG_DUTY_CEILING,   32'd0,          12'd0,    1'b0, 16'd0,     1'b0, 8'd0},
    '{ROW_SAMPLE,    REG_STEP_BASE,      32'd0,          12'd777,  1'b1, 16'd0,     1'b0, 8'd0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  spn_sample_if sample_if ();
  spn_result_if result_if ();

  sine_pwm_reference_nco dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .sample_i   (sample_if),
    .result_o   (result_if)
  );

  // Predictor state: a private copy of the registers and the accumulator.
  logic [STEP_W-1:0]   exp_step_base;
  logic [SLOPE_W-1:0]  exp_step_slope;
  logic [STEP_W-1:0]   exp_step_limit;
  logic [PERIOD_W-1:0] exp_period;
  logic [DUTY_W-1:0]   exp_floor;
  logic [DUTY_W-1:0]   exp_ceiling;
  logic [PHASE_W-1:0]  nco_phase;
  logic [15:0]         sine_duty [TABLE_LEN];

  pwm_result_t pending_results [$];
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_hold_cycles;
  int unsigned failures;
  int unsigned samples_sent;
  int unsigned results_checked;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Offset sine in Q0.16: 0.5 + 0.5*sin(2*pi*i/TABLE_LEN), built with an
  // integer Horner series in Q30 and rounded to the nearest step.
  function automatic logic [15:0] sine_entry(input int unsigned i);
    logic [63:0] turn;
    logic [63:0] frac;
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] d;
    logic [63:0] v;
    logic [1:0]  quadrant;
    turn     = (64'(i) << 32) / 64'(TABLE_LEN);
    quadrant = turn[31:30];
    frac     = {34'd0, turn[29:0]};
    u        = quadrant[0] ? (Q30_UNIT - frac) : frac;
    x        = (u * Q30_QUARTER_TURN) >> 30;
    x2       = (x * x) >> 30;
    t        = Q30_UNIT;
    for (int k = 0; k < 6; k++) begin
      t = Q30_UNIT - ((x2 * t) >> 30) / HORNER_DIV[k];
    end
    s = (x * t) >> 30;
    if (s > Q30_UNIT) begin
      s = Q30_UNIT;
    end
    d = ((s << 15) + (64'd1 << 29)) >> 30;
    if (quadrant[1]) begin
      v = (d >= 64'd32768) ? 64'd0 : (64'd32768 - d);
    end else begin
      v = 64'd32768 + d;
    end
    if (v > 64'hFFFF) begin
      v = 64'hFFFF;
    end
    return v[15:0];
  endfunction

  // Advances the accumulator by one sample and returns the PWM result.
  function automatic pwm_result_t advance_nco(input logic [SAMPLE_FIELD_W-1:0] sample);
    logic [63:0]         step;
    logic [DUTY_W-1:0]   duty;
    logic [31:0]         scaled;
    logic [IDX_FIELD_W-1:0] slot;
    pwm_result_t         res;
    step = 64'(exp_step_base) + 64'(sample) * 64'(exp_step_slope);
    if (step > 64'(exp_step_limit)) begin
      step = 64'(exp_step_limit);
    end
    nco_phase = nco_phase + step[PHASE_W-1:0];
    slot      = nco_phase[PHASE_W-1:FRAC_BITS];
    duty      = sine_duty[slot];
    if (duty < exp_floor) begin
      duty = exp_floor;
    end
    if (duty > exp_ceiling) begin
      duty = exp_ceiling;
    end
    scaled            = 32'(duty) * 32'(exp_period);
    res.compare_value = scaled[31:16];
    res.table_index   = slot;
    return res;
  endfunction

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_STEP_BASE:      exp_step_base  = data;
      REG_STEP_PER_COUNT: exp_step_slope = data[SLOPE_W-1:0];
      REG_STEP_LIMIT:     exp_step_limit = data;
      REG_CARRIER_PERIOD: exp_period     = data[PERIOD_W-1:0];
      REG_DUTY_FLOOR:     exp_floor      = data[DUTY_W-1:0];
      REG_DUTY_CEILING:   exp_ceiling    = data[DUTY_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_FIELD_W-1:0] sample,
                             input logic fix_cmp, input logic [CMP_W-1:0] cmp,
                             input logic fix_idx, input logic [IDX_FIELD_W-1:0] idx);
    pwm_result_t want;
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid          <= 1'b1;
    sample_if.control_sample <= sample;
    do @(posedge clk); while (sample_if.ready !== 1'b1);
    want = advance_nco(sample);
    if (fix_cmp) begin
      want.compare_value = cmp;
    end
    if (fix_idx) begin
      want.table_index = idx;
    end
    pending_results.push_back(want);
    samples_sent++;
  endtask

  // Stops offering samples, waits for every outstanding result, then lets
  // the pipeline settle.
  task automatic drain_results(input int unsigned settle);
    sample_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_word(input logic [CFG_DATA_W-1:0] ones);
    case ($urandom_range(5))
      0:       return '0;
      1:       return ones;
      2:       return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic program_phase(input int unsigned phase);
    if (phase == 0) begin
      write_reg(REG_STEP_BASE, 32'(STEP_BASE_RST));
      write_reg(REG_STEP_PER_COUNT, 32'(STEP_PER_COUNT_RST));
      write_reg(REG_STEP_LIMIT, 32'(STEP_LIMIT_RST));
      write_reg(REG_CARRIER_PERIOD, 32'(CARRIER_PERIOD_RST));
      write_reg(REG_DUTY_FLOOR, 32'(DUTY_FLOOR_RST));
      write_reg(REG_DUTY_CEILING, 32'(DUTY_CEILING_RST));
    end else if (phase % 2 == 1) begin
      // Realistic low-frequency settings with a sensible duty window.
      write_reg(REG_STEP_BASE, $urandom_range(32'h0400_0000));
      write_reg(REG_STEP_PER_COUNT, $urandom_range(32'h0000_8000));
      write_reg(REG_STEP_LIMIT, $urandom_range(32'h0800_0000, 32'h2000_0000));
      write_reg(REG_CARRIER_PERIOD, $urandom_range(1, 65535));
      write_reg(REG_DUTY_FLOOR, $urandom_range(16'h1000));
      write_reg(REG_DUTY_CEILING, $urandom_range(16'hE000, 16'hFFFF));
    end else begin
      write_reg(REG_STEP_BASE, pick_word(32'hFFFF_FFFF));
      write_reg(REG_STEP_PER_COUNT, pick_word(32'h000F_FFFF));
      write_reg(REG_STEP_LIMIT, pick_word(32'hFFFF_FFFF));
      write_reg(REG_CARRIER_PERIOD, pick_word(32'h0000_FFFF));
      write_reg(REG_DUTY_FLOOR, pick_word(32'h0000_FFFF));
      write_reg(REG_DUTY_CEILING, pick_word(32'h0000_FFFF));
    end
    if ($urandom_range(1) == 1) begin
      write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SAMPLE_FIELD_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom_range(4095);
    endcase
  endfunction

  // Result side: random back-pressure, an optional long hold-off, and the
  // comparison of each transaction against the oldest expectation.
  initial begin
    pwm_result_t want;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: compare_value %0d table_index %0d",
                 result_if.compare_value, result_if.table_index);
          failures++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (result_if.compare_value !== want.compare_value) begin
            $error("compare_value: expected %0d, got %0d",
                   want.compare_value, result_if.compare_value);
            failures++;
          end
          if (result_if.table_index !== want.table_index) begin
            $error("table_index: expected %0d, got %0d",
                   want.table_index, result_if.table_index);
            failures++;
          end
        end
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d results still outstanding", pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic in_writes;
    rst_n                    <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_idx                  <= '0;
    cfg_wdata                <= '0;
    sample_if.valid          <= 1'b0;
    sample_if.control_sample <= '0;
    tx_idle_pct    = IDLE_PCT;
    rx_idle_pct    = IDLE_PCT;
    rx_hold_cycles = 0;
    failures       = 0;
    samples_sent   = 0;
    results_checked = 0;
    exp_step_base  = STEP_BASE_RST;
    exp_step_slope = STEP_PER_COUNT_RST;
    exp_step_limit = STEP_LIMIT_RST;
    exp_period     = CARRIER_PERIOD_RST;
    exp_floor      = DUTY_FLOOR_RST;
    exp_ceiling    = DUTY_CEILING_RST;
    nco_phase      = '0;
    for (int i = 0; i < TABLE_LEN; i++) begin
      sine_duty[i] = sine_entry(i);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_writes = 1'b0;
    foreach (DIRECTED_PLAN[r]) begin
      if (DIRECTED_PLAN[r].kind == ROW_REG_WRITE) begin
        if (!in_writes) begin
          drain_results(SETTLE_CYCLES);
        end
        in_writes = 1'b1;
        write_reg(DIRECTED_PLAN[r].reg_idx, DIRECTED_PLAN[r].reg_data);
      end else begin
        if (in_writes) begin
          cfg_we <= 1'b0;
        end
        in_writes = 1'b0;
        send_sample(DIRECTED_PLAN[r].sample, DIRECTED_PLAN[r].fix_cmp, DIRECTED_PLAN[r].cmp,
                    DIRECTED_PLAN[r].fix_idx, DIRECTED_PLAN[r].idx);
      end
    end

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results(SETTLE_CYCLES);
      program_phase(phase);
      tx_idle_pct = (phase == 3) ? 0 : IDLE_PCT;
      rx_idle_pct = (phase == 3) ? 0 : IDLE_PCT;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 20) begin
          // Block the result side while samples keep coming back to back,
          // so the block fills up and stalls its input.
          rx_hold_cycles = HOLD_CYCLES;
          tx_idle_pct    = 0;
        end
        if (phase == 2 && n == 60) begin
          tx_idle_pct = IDLE_PCT;
        end
        if (phase == 5 && n == PHASE_ITEMS / 2) begin
          drain_results(0);
        end
        send_sample(pick_sample(), 1'b0, '0, 1'b0, '0);
      end
    end

    drain_results(TAIL_CYCLES);
    $display("Sent %0d control samples and checked %0d results across the directed plan",
             samples_sent, results_checked);
    $display("and %0d random register settings, with stalls, hold-off and idle-free spells.",
             RANDOM_PHASES);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
